// ===== rtl/lfps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_pkg
// Types, widths, codes and reset values shared by the line follower PID
// steering block.
// ----------------------------------------------------------------------------
package lfps_pkg;

   // Field widths.
   localparam int ERR_W   = 2;
   localparam int DIFF_W  = 3;
   localparam int SUM_W   = 16;
   localparam int GAIN_W  = 11;
   localparam int PWM_W   = 10;
   localparam int PULSE_W = 12;
   localparam int IDX_W   = 3;
   localparam int PID_W   = 28;

   // Product widths of the three PID terms.
   localparam int PROD_P_W = GAIN_W + ERR_W;
   localparam int PROD_I_W = GAIN_W + SUM_W;
   localparam int PROD_D_W = GAIN_W + DIFF_W;

   // Default servo center and work queue depth.
   localparam int SERVO_CENTRE_DEFAULT = 1500;
   localparam int QUEUE_DEPTH_DEFAULT  = 2;

   // Integral saturation limit and pulse ceiling.
   localparam int SUM_LIMIT = 32767;
   localparam int PULSE_MAX = 4095;

   // Steering error codes.
   localparam logic signed [ERR_W-1:0] ERR_RIGHT    = -2'sd1;
   localparam logic signed [ERR_W-1:0] ERR_STRAIGHT = 2'sd0;
   localparam logic signed [ERR_W-1:0] ERR_LEFT     = 2'sd1;

   // Sensor patterns, left sensor in the top bit.
   localparam logic [2:0] PAT_NONE       = 3'b000;
   localparam logic [2:0] PAT_RIGHT_ONLY = 3'b001;
   localparam logic [2:0] PAT_OUTER_PAIR = 3'b101;
   localparam logic [2:0] PAT_LEFT_PAIR  = 3'b110;
   localparam logic [2:0] PAT_ALL        = 3'b111;

   // Patterns that keep the previous error and motor speeds.
   localparam logic [2:0] PAT_MID_ONLY   = 3'b010;
   localparam logic [2:0] PAT_MID_RIGHT  = 3'b011;
   localparam logic [2:0] PAT_LEFT_ONLY  = 3'b100;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
   localparam logic [IDX_W-1:0] REG_FAST_PWM   = 3'd3;
   localparam logic [IDX_W-1:0] REG_SLOW_PWM   = 3'd4;

   // Configuration reset values.
   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RESET  = 11'sd100;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RESET = 11'sd0;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RESET = 11'sd0;
   localparam logic [PWM_W-1:0]         FAST_PWM_RESET   = 10'd400;
   localparam logic [PWM_W-1:0]         SLOW_PWM_RESET   = 10'd100;

   // Input transaction.
   typedef struct packed {
      logic sensor_left;
      logic sensor_mid;
      logic sensor_right;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic signed [ERR_W-1:0] steer_error;
      logic [PWM_W-1:0]        left_motor_pwm;
      logic [PWM_W-1:0]        right_motor_pwm;
      logic                    pause_request;
      logic [PULSE_W-1:0]      servo_pulse;
      logic                    servo_clipped;
   } rsp_type;

   // Configuration write transaction.
   typedef struct packed {
      logic [IDX_W-1:0]  reg_index;
      logic [GAIN_W-1:0] wdata;
   } csr_type;

   // PID gains.
   typedef struct packed {
      logic signed [GAIN_W-1:0] prop;
      logic signed [GAIN_W-1:0] integ;
      logic signed [GAIN_W-1:0] deriv;
   } gains_type;

   // Motor PWM settings.
   typedef struct packed {
      logic [PWM_W-1:0] fast;
      logic [PWM_W-1:0] slow;
   } pwm_cfg_type;

   // Classified sample handed from the front end to the back end.
   typedef struct packed {
      logic signed [ERR_W-1:0]  error;
      logic signed [DIFF_W-1:0] diff;
      logic signed [SUM_W-1:0]  error_sum;
      logic [PWM_W-1:0]         left_pwm;
      logic [PWM_W-1:0]         right_pwm;
      logic                     pause;
      logic                     sum_clipped;
   } work_type;

endpackage

// ===== rtl/lfps_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lfps_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lfps_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_front
// Accepts sensor samples, decodes the steering error and motor PWMs, and
// updates the integral and previous-error state.
// ----------------------------------------------------------------------------
module lfps_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lfps_pkg::req_type    req_data,
   input  lfps_pkg::pwm_cfg_type pwm_cfg,
   output logic                 push_valid,
   input  logic                 push_ready,
   output lfps_pkg::work_type   push_data
);

   logic signed [lfps_pkg::ERR_W-1:0]  held_error_ff, held_error_in;
   logic signed [lfps_pkg::ERR_W-1:0]  prior_error_ff;
   logic signed [lfps_pkg::SUM_W-1:0]  error_sum_ff, error_sum_in;
   logic [lfps_pkg::PWM_W-1:0]         held_left_ff, held_left_in;
   logic [lfps_pkg::PWM_W-1:0]         held_right_ff, held_right_in;
   logic                               pause;
   logic                               sum_clipped;
   logic signed [lfps_pkg::SUM_W:0]    sum_wide;
   logic signed [lfps_pkg::DIFF_W-1:0] diff;
   logic [2:0]                         pattern;
   logic                               fire;

   assign req_ready  = push_ready;
   assign fire       = req_valid && push_ready;
   assign push_valid = fire;
   assign pattern    = {req_data.sensor_left, req_data.sensor_mid, req_data.sensor_right};

   // Decode the sensor pattern; unknown patterns keep the held values.
   always_comb begin
      held_error_in = held_error_ff;
      held_left_in  = held_left_ff;
      held_right_in = held_right_ff;
      pause         = 1'b0;
      case (pattern)
         lfps_pkg::PAT_OUTER_PAIR, lfps_pkg::PAT_LEFT_PAIR: begin
            held_error_in = lfps_pkg::ERR_STRAIGHT;
            held_left_in  = pwm_cfg.fast;
            held_right_in = pwm_cfg.fast;
         end
         lfps_pkg::PAT_ALL: begin
            held_error_in = lfps_pkg::ERR_LEFT;
            held_left_in  = pwm_cfg.slow;
            held_right_in = pwm_cfg.fast;
            pause         = 1'b1;
         end
         lfps_pkg::PAT_NONE, lfps_pkg::PAT_RIGHT_ONLY: begin
            held_error_in = lfps_pkg::ERR_RIGHT;
            held_left_in  = pwm_cfg.fast;
            held_right_in = pwm_cfg.slow;
            pause         = 1'b1;
         end
         default: begin
            pause = 1'b0;
         end
      endcase
   end

   // Saturating integral and error difference.
   always_comb begin
      sum_wide = {error_sum_ff[lfps_pkg::SUM_W-1], error_sum_ff}
               + {{(lfps_pkg::SUM_W+1-lfps_pkg::ERR_W){held_error_in[lfps_pkg::ERR_W-1]}},
                  held_error_in};
      sum_clipped  = 1'b0;
      error_sum_in = sum_wide[lfps_pkg::SUM_W-1:0];
      if (sum_wide > (lfps_pkg::SUM_W+1)'(lfps_pkg::SUM_LIMIT)) begin
         error_sum_in = lfps_pkg::SUM_W'(lfps_pkg::SUM_LIMIT);
         sum_clipped  = 1'b1;
      end else if (sum_wide < -(lfps_pkg::SUM_W+1)'(lfps_pkg::SUM_LIMIT)) begin
         error_sum_in = -lfps_pkg::SUM_W'(lfps_pkg::SUM_LIMIT);
         sum_clipped  = 1'b1;
      end
      diff = {held_error_in[lfps_pkg::ERR_W-1], held_error_in}
           - {prior_error_ff[lfps_pkg::ERR_W-1], prior_error_ff};
   end

   // Work record for the back end.
   always_comb begin
      push_data.error       = held_error_in;
      push_data.diff        = diff;
      push_data.error_sum   = error_sum_in;
      push_data.left_pwm    = held_left_in;
      push_data.right_pwm   = held_right_in;
      push_data.pause       = pause;
      push_data.sum_clipped = sum_clipped;
   end

   // Controller state advances once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_error_ff  <= '0;
         prior_error_ff <= '0;
         error_sum_ff   <= '0;
         held_left_ff   <= '0;
         held_right_ff  <= '0;
      end else if (fire) begin
         held_error_ff  <= held_error_in;
         prior_error_ff <= held_error_in;
         error_sum_ff   <= error_sum_in;
         held_left_ff   <= held_left_in;
         held_right_ff  <= held_right_in;
      end
   end

endmodule

// ===== rtl/lfps_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lfps_queue #(
   parameter int DEPTH = lfps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  lfps_pkg::work_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output lfps_pkg::work_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lfps_pkg::work_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/lfps_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_back
// Two-stage PID datapath: term products, then sum, servo pulse and
// saturation into the result register.
// ----------------------------------------------------------------------------
module lfps_back #(
   parameter int SERVO_CENTRE = lfps_pkg::SERVO_CENTRE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  lfps_pkg::gains_type gains,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  lfps_pkg::work_type  pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lfps_pkg::rsp_type   rsp_data
);

   localparam logic signed [lfps_pkg::PID_W-1:0] CENTRE = lfps_pkg::PID_W'(SERVO_CENTRE);
   localparam logic signed [lfps_pkg::PID_W-1:0] PULSE_TOP =
      lfps_pkg::PID_W'(lfps_pkg::PULSE_MAX);

   logic                                 s1_valid_ff;
   lfps_pkg::work_type                   s1_work_ff;
   logic signed [lfps_pkg::PROD_P_W-1:0] prod_p_ff, prod_p_in;
   logic signed [lfps_pkg::PROD_I_W-1:0] prod_i_ff, prod_i_in;
   logic signed [lfps_pkg::PROD_D_W-1:0] prod_d_ff, prod_d_in;
   logic                                 out_valid_ff;
   lfps_pkg::rsp_type                    out_ff, out_in;
   logic signed [lfps_pkg::PID_W-1:0]    pid;
   logic signed [lfps_pkg::PID_W-1:0]    pulse_full;
   logic                                 out_en;
   logic                                 s1_en;

   // Stages advance whenever the stage ahead can take their contents.
   assign out_en    = !out_valid_ff || rsp_ready;
   assign s1_en     = !s1_valid_ff || out_en;
   assign pop_ready = s1_en;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Term products.
   assign prod_p_in = gains.prop * pop_data.error;
   assign prod_i_in = gains.integ * pop_data.error_sum;
   assign prod_d_in = gains.deriv * pop_data.diff;

   // Sum of terms, servo pulse and its saturation.
   always_comb begin
      pid = lfps_pkg::PID_W'(prod_p_ff) + lfps_pkg::PID_W'(prod_i_ff)
          + lfps_pkg::PID_W'(prod_d_ff);
      pulse_full = CENTRE - pid;
      out_in.steer_error     = s1_work_ff.error;
      out_in.left_motor_pwm  = s1_work_ff.left_pwm;
      out_in.right_motor_pwm = s1_work_ff.right_pwm;
      out_in.pause_request   = s1_work_ff.pause;
      out_in.servo_pulse     = pulse_full[lfps_pkg::PULSE_W-1:0];
      out_in.servo_clipped   = s1_work_ff.sum_clipped;
      if (pulse_full < 0) begin
         out_in.servo_pulse   = '0;
         out_in.servo_clipped = 1'b1;
      end else if (pulse_full > PULSE_TOP) begin
         out_in.servo_pulse   = lfps_pkg::PULSE_W'(lfps_pkg::PULSE_MAX);
         out_in.servo_clipped = 1'b1;
      end
   end

   // Valid bits of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= pop_valid;
         end
         if (out_en) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_work_ff <= pop_data;
         prod_p_ff  <= prod_p_in;
         prod_i_ff  <= prod_i_in;
         prod_d_ff  <= prod_d_in;
      end
      if (out_en) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== rtl/line_follow_pid_steering.sv =====
`timescale 1ns / 1ps
// A transaction accepted on the request channel is written into the work queue,
// then registered in the product stage and in the result register before it is offered.
// Throughput: one transaction per cycle while results are taken, set by the combinational
// front end decode and the two-stage PID datapath; a full work queue holds off requests.
// Reset is synchronous: it empties the queue and pipeline, clears the
// controller state to zero and loads the register defaults.
// ----------------------------------------------------------------------------
// line_follow_pid_steering
// Three-sensor line follower steering: sensor decode, PID step and servo
// pulse, with a register write port for gains and motor PWM settings.
// ----------------------------------------------------------------------------
module line_follow_pid_steering #(
   parameter int SERVO_CENTRE = lfps_pkg::SERVO_CENTRE_DEFAULT,
   parameter int QUEUE_DEPTH  = lfps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   lfps_stream_if.sink   req_if,
   lfps_stream_if.source rsp_if,
   lfps_stream_if.sink   csr_if
);

   lfps_pkg::gains_type   gains_ff;
   lfps_pkg::pwm_cfg_type pwm_ff;
   lfps_pkg::work_type    push_data;
   lfps_pkg::work_type    pop_data;
   logic                  push_valid;
   logic                  push_ready;
   logic                  pop_valid;
   logic                  pop_ready;
   logic                  csr_fire;

   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop  <= lfps_pkg::PROP_GAIN_RESET;
         gains_ff.integ <= lfps_pkg::INTEG_GAIN_RESET;
         gains_ff.deriv <= lfps_pkg::DERIV_GAIN_RESET;
         pwm_ff.fast    <= lfps_pkg::FAST_PWM_RESET;
         pwm_ff.slow    <= lfps_pkg::SLOW_PWM_RESET;
      end else if (csr_fire) begin
         case (csr_if.data.reg_index)
            lfps_pkg::REG_PROP_GAIN: begin
               gains_ff.prop <= csr_if.data.wdata;
            end
            lfps_pkg::REG_INTEG_GAIN: begin
               gains_ff.integ <= csr_if.data.wdata;
            end
            lfps_pkg::REG_DERIV_GAIN: begin
               gains_ff.deriv <= csr_if.data.wdata;
            end
            lfps_pkg::REG_FAST_PWM: begin
               pwm_ff.fast <= csr_if.data.wdata[lfps_pkg::PWM_W-1:0];
            end
            lfps_pkg::REG_SLOW_PWM: begin
               pwm_ff.slow <= csr_if.data.wdata[lfps_pkg::PWM_W-1:0];
            end
            default: begin
               pwm_ff <= pwm_ff;
            end
         endcase
      end
   end

   // Front end: decode and controller state.
   lfps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_data   (req_if.data),
      .pwm_cfg    (pwm_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Work queue between front and back ends.
   lfps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back end: PID arithmetic and result register.
   lfps_back #(
      .SERVO_CENTRE (SERVO_CENTRE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_if.data)
   );

endmodule

// ===== rtl/lfps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_checker
// Port-level checks of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
module lfps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lfps_pkg::rsp_type rsp_data
);

   logic [2:0] pending_ff, pending_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Count of transactions accepted but not yet answered.
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A result never appears without an outstanding transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result without an accepted transaction");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A pause request only comes with a turn error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pause_request |-> rsp_data.steer_error != lfps_pkg::ERR_STRAIGHT)
      else $error("pause request on a straight error");

   // Reset empties the result register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind line_follow_pid_steering lfps_checker u_lfps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);

// ===== dv/lfps_steer_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_steer_check
// Watches the sample, steering and register channels of the line follower
// PID steering block. It keeps its own copy of the controller state and
// settings, predicts the steering result of each sensor sample and compares
// every returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lfps_steer_check
   import lfps_pkg::*;
#(
   parameter int SERVO_CENTRE = SERVO_CENTRE_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  csr_type csr_data,
   output int      pending,
   output int      mismatches,
   output int      checked
);

   // Controller settings as the register port last wrote them.
   logic signed [GAIN_W-1:0] kp, ki, kd;
   logic [PWM_W-1:0]         pwm_fast, pwm_slow;

   // Controller state carried from one sample to the next.
   logic signed [ERR_W-1:0]  cur_err, last_err;
   logic signed [SUM_W-1:0]  err_integral;
   logic [PWM_W-1:0]         left_pwm_q, right_pwm_q;

   // Steering results still owed by the block, oldest first.
   rsp_type steering_due_q[$];

   // Decode one sensor sample, run the PID step and form the servo pulse.
   function automatic rsp_type predict_steering(input req_type s);
      logic [2:0] pattern;
      logic       pause, clip;
      int         sum;
      longint     pid, pulse;
      rsp_type    r;
      pattern = {s.sensor_left, s.sensor_mid, s.sensor_right};
      pause = 1'b0;
      clip  = 1'b0;
      case (pattern)
         PAT_OUTER_PAIR, PAT_LEFT_PAIR: begin
            cur_err     = ERR_STRAIGHT;
            left_pwm_q  = pwm_fast;
            right_pwm_q = pwm_fast;
         end
         PAT_ALL: begin
            cur_err     = ERR_LEFT;
            left_pwm_q  = pwm_slow;
            right_pwm_q = pwm_fast;
            pause       = 1'b1;
         end
         PAT_NONE, PAT_RIGHT_ONLY: begin
            cur_err     = ERR_RIGHT;
            left_pwm_q  = pwm_fast;
            right_pwm_q = pwm_slow;
            pause       = 1'b1;
         end
         // Any other pattern keeps the previous error and motor speeds.
         default: ;
      endcase

      // The integral saturates symmetrically and flags the clip.
      sum = int'(err_integral) + int'(cur_err);
      if (sum > SUM_LIMIT) begin
         sum  = SUM_LIMIT;
         clip = 1'b1;
      end
      if (sum < -SUM_LIMIT) begin
         sum  = -SUM_LIMIT;
         clip = 1'b1;
      end
      err_integral = sum[SUM_W-1:0];

      pid = longint'(kp) * longint'(cur_err)
          + longint'(ki) * longint'(sum)
          + longint'(kd) * (longint'(cur_err) - longint'(last_err));
      last_err = cur_err;

      // The servo pulse is centered and saturated to the pulse range.
      pulse = longint'(SERVO_CENTRE) - pid;
      if (pulse < 0) begin
         pulse = 0;
         clip  = 1'b1;
      end
      if (pulse > PULSE_MAX) begin
         pulse = PULSE_MAX;
         clip  = 1'b1;
      end

      r.steer_error     = cur_err;
      r.left_motor_pwm  = left_pwm_q;
      r.right_motor_pwm = right_pwm_q;
      r.pause_request   = pause;
      r.servo_pulse     = pulse[PULSE_W-1:0];
      r.servo_clipped   = clip;
      return r;
   endfunction

   // Report one field that differs from its prediction.
   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Settings, comparison and prediction, in that order, at every clock edge.
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         kp           = PROP_GAIN_RESET;
         ki           = INTEG_GAIN_RESET;
         kd           = DERIV_GAIN_RESET;
         pwm_fast     = FAST_PWM_RESET;
         pwm_slow     = SLOW_PWM_RESET;
         cur_err      = ERR_STRAIGHT;
         last_err     = ERR_STRAIGHT;
         err_integral = '0;
         left_pwm_q   = '0;
         right_pwm_q  = '0;
         steering_due_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_data.reg_index)
               REG_PROP_GAIN:  kp = csr_data.wdata;
               REG_INTEG_GAIN: ki = csr_data.wdata;
               REG_DERIV_GAIN: kd = csr_data.wdata;
               REG_FAST_PWM:   pwm_fast = csr_data.wdata[PWM_W-1:0];
               REG_SLOW_PWM:   pwm_slow = csr_data.wdata[PWM_W-1:0];
               // Writes to unused indexes change nothing.
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (steering_due_q.size() == 0) begin
               $display("%0t ns: steering result with none expected, actual %p",
                        $time, rsp_data);
               mismatches++;
            end else begin
               due = steering_due_q.pop_front();
               check_field("steer_error", due.steer_error, rsp_data.steer_error);
               check_field("left_motor_pwm", due.left_motor_pwm, rsp_data.left_motor_pwm);
               check_field("right_motor_pwm", due.right_motor_pwm,
                           rsp_data.right_motor_pwm);
               check_field("pause_request", due.pause_request, rsp_data.pause_request);
               check_field("servo_pulse", due.servo_pulse, rsp_data.servo_pulse);
               check_field("servo_clipped", due.servo_clipped, rsp_data.servo_clipped);
               checked++;
            end
         end

         if (req_valid && req_ready)
            steering_due_q.push_back(predict_steering(req_data));
      end
      pending <= steering_due_q.size();
   end

endmodule

// ===== dv/tb_line_follow_pid_steering.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_follow_pid_steering
// Drives sensor samples and register writes into the line follower PID
// steering block: a short directed opening, randomized phases under varied
// gains, PWM settings and flow control, then a steady turn one way and then
// the other so the integral ramps down and back up. Results are checked by the
// steering checker beside the block.
// ----------------------------------------------------------------------------
module tb_line_follow_pid_steering;
   import lfps_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int SERVO_CENTRE   = SERVO_CENTRE_DEFAULT;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_SLACK    = 8;
   localparam int HOLD_CYCLES    = 80;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_SAMPLES  = 110;
   localparam int WIND_DOWN      = 30;
   localparam int WIND_UP        = 60;

   logic clock = 1'b0;
   logic reset;

   lfps_stream_if #(.payload_type(req_type)) req_if ();
   lfps_stream_if #(.payload_type(rsp_type)) rsp_if ();
   lfps_stream_if #(.payload_type(csr_type)) csr_if ();

   // Flow-control knobs shared by the sample sender and the result receiver.
   int src_idle_pct  = 0;
   int sink_idle_pct = 0;
   bit hold_rsp      = 1'b0;

   int pending, mismatches, checked;
   int samples_sent = 0;
   int settings_used = 0;

   csr_type reg_writes[$];

   line_follow_pid_steering #(
      .SERVO_CENTRE(SERVO_CENTRE)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   lfps_steer_check #(
      .SERVO_CENTRE(SERVO_CENTRE)
   ) steer_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_data   (req_if.data),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_data   (rsp_if.data),
      .csr_valid  (csr_if.valid),
      .csr_ready  (csr_if.ready),
      .csr_data   (csr_if.data),
      .pending    (pending),
      .mismatches (mismatches),
      .checked    (checked)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Idle stretches are mostly short, with an occasional long one.
   function automatic int idle_len();
      if ($urandom_range(9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Gains are either small, for unsaturated pulses, or anywhere in range.
   function automatic int pick_gain();
      if ($urandom_range(2) == 0)
         return int'($urandom_range(2047)) - 1024;
      return int'($urandom_range(80)) - 40;
   endfunction

   // PWM settings sometimes exceed 999 and the PWM register's 10-bit range.
   function automatic int pick_pwm();
      if ($urandom_range(7) == 0)
         return $urandom_range(2047);
      return $urandom_range(999);
   endfunction

   // Offer one sensor sample, after an optional idle gap, until it is taken.
   task automatic send_sample(input logic [2:0] pattern);
      int gap;
      if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
         gap = idle_len();
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= '{sensor_left: pattern[2], sensor_mid: pattern[1],
                        sensor_right: pattern[0]};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      samples_sent++;
   endtask

   // Stop offering samples and wait until every result has come back.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Queue all five controller registers behind any queued writes and
   // send them back to back.
   task automatic set_controller(input int kp, input int ki, input int kd,
                                 input int fast, input int slow);
      reg_writes.push_back('{reg_index: REG_PROP_GAIN,  wdata: kp[GAIN_W-1:0]});
      reg_writes.push_back('{reg_index: REG_INTEG_GAIN, wdata: ki[GAIN_W-1:0]});
      reg_writes.push_back('{reg_index: REG_DERIV_GAIN, wdata: kd[GAIN_W-1:0]});
      reg_writes.push_back('{reg_index: REG_FAST_PWM,   wdata: fast[GAIN_W-1:0]});
      reg_writes.push_back('{reg_index: REG_SLOW_PWM,   wdata: slow[GAIN_W-1:0]});
      while (reg_writes.size() > 0) begin
         csr_if.valid <= 1'b1;
         csr_if.data  <= reg_writes.pop_front();
         @(posedge clock);
         while (!csr_if.ready) @(posedge clock);
      end
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   // Result receiver: random stalls, plus a long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (sink_idle_pct > 0 && $urandom_range(99) < sink_idle_pct) begin
            rsp_if.ready <= 1'b0;
            stall_left = idle_len() - 1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no channel moves a transaction for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
             || (csr_if.valid && csr_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending);
      $display("Test completed with failures");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      logic [2:0] opening[$];
      logic [2:0] swing_a[$];
      logic [2:0] swing_b[$];
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: the held patterns first, while the held state is zero,
      // then every decode pattern.
      opening = '{PAT_MID_ONLY, PAT_MID_RIGHT, PAT_LEFT_ONLY, PAT_NONE, PAT_RIGHT_ONLY,
                  PAT_OUTER_PAIR, PAT_LEFT_PAIR, PAT_ALL, PAT_LEFT_ONLY, PAT_NONE,
                  PAT_MID_RIGHT};
      src_idle_pct  = 20;
      sink_idle_pct = 20;
      foreach (opening[i]) send_sample(opening[i]);

      // Largest positive P and D gains: full error swings clip the pulse both ways.
      wait_idle();
      set_controller(1023, 0, 1023, 0, 999);
      swing_a = '{PAT_ALL, PAT_NONE, PAT_ALL, PAT_MID_ONLY, PAT_OUTER_PAIR};
      foreach (swing_a[i]) send_sample(swing_a[i]);

      // Most negative gains, and PWM values beyond 999.
      wait_idle();
      set_controller(-1024, -1024, -1024, 2047, 1000);
      swing_b = '{PAT_ALL, PAT_NONE, PAT_LEFT_PAIR, PAT_RIGHT_ONLY};
      foreach (swing_b[i]) send_sample(swing_b[i]);

      // Random phases under varied settings and flow control.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         if (phase == 2)
            reg_writes.push_back('{reg_index: IDX_W'(REG_SLOW_PWM + 1 + $urandom_range(2)),
                                   wdata: GAIN_W'($urandom_range(2047))});
         set_controller(pick_gain(), pick_gain(), pick_gain(), pick_pwm(), pick_pwm());
         src_idle_pct  = (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
         sink_idle_pct = (phase % 4 == 1) ? 0 : $urandom_range(10, 60);
         // One phase keeps the receiver off while samples keep coming.
         if (phase == 3) begin
            src_idle_pct = 0;
            hold_rsp     = 1'b1;
         end
         repeat (PHASE_SAMPLES) send_sample(3'($urandom_range(7)));
      end

      // Integral ramp down under a steady right turn, then back up under a steady left turn.
      wait_idle();
      set_controller(0, 100, 0, pick_pwm(), pick_pwm());
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      repeat (WIND_DOWN) send_sample(PAT_NONE);
      repeat (WIND_UP) send_sample(PAT_ALL);

      wait_idle();
      $display("Sent %0d sensor samples under %0d controller settings and checked %0d",
               samples_sent, settings_used, checked);
      $display("steering results, including pulse saturation and integral ramps.");
      if (mismatches == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
